// ===== design/htnc_pkg.sv =====
// ---------------------------------------------------------------------------
// htnc_pkg: shared definitions for the tag nesting checker
// Sizes, character codes, parse modes, error codes and the structs that
// pass between the parser, the stack memories and the output stage.
// ---------------------------------------------------------------------------
package htnc_pkg;

    // Sizing
    localparam int MAX_TAG_LEN = 16;
    localparam int STACK_DEPTH = 16;

    localparam int LEN_W      = $clog2(MAX_TAG_LEN + 1);
    localparam int COL_W      = $clog2(MAX_TAG_LEN);
    localparam int SP_W       = $clog2(STACK_DEPTH + 1);
    localparam int ROW_W      = $clog2(STACK_DEPTH);
    localparam int TAG_WORDS  = STACK_DEPTH * (2 ** COL_W);
    localparam int TAG_ADDR_W = $clog2(TAG_WORDS);

    // Character codes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_G     = 8'h67;

    typedef enum logic [1:0] {
        MODE_OUTSIDE,
        MODE_AFTER_LT,
        MODE_OPEN,
        MODE_CLOSE
    } mode_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MISMATCH = 3'd1,
        ERR_EMPTY    = 3'd2,
        ERR_UNCLOSED = 3'd3,
        ERR_UNTERM   = 3'd4,
        ERR_OVERFLOW = 3'd5
    } err_t;

    // Parser to stack memories
    typedef struct packed {
        logic                  tag_wr;
        logic [TAG_ADDR_W-1:0] tag_wr_addr;
        logic [7:0]            tag_wr_data;
        logic                  len_wr;
        logic [ROW_W-1:0]      len_wr_addr;
        logic [LEN_W-1:0]      len_wr_data;
        logic                  rd;
        logic [TAG_ADDR_W-1:0] tag_rd_addr;
        logic [ROW_W-1:0]      len_rd_addr;
    } ram_req_t;

    // Stack memories to parser (registered read data)
    typedef struct packed {
        logic [7:0]       tag;
        logic [LEN_W-1:0] len;
    } ram_rsp_t;

    // Parser to output stage
    typedef struct packed {
        logic valid;
        logic verdict;
        err_t kind;
    } result_t;

endpackage

// ===== design/htnc_if.sv =====
// ---------------------------------------------------------------------------
// htnc_if: stream interfaces of the tag nesting checker
// Character stream in, verdict stream out; valid/ready transfer.
// ---------------------------------------------------------------------------
interface htnc_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface htnc_verdict_if;
    logic       valid;
    logic       ready;
    logic       verdict;
    logic [2:0] error_kind;

    modport source (output valid, output verdict, output error_kind, input ready);
    modport sink   (input valid, input verdict, input error_kind, output ready);
endinterface

// ===== design/html_tag_nesting_checker.sv =====
// ---------------------------------------------------------------------------
// html_tag_nesting_checker: balanced tag matching over a character stream
// Takes one character per transfer and gives one verdict on the character
// marked last, then starts afresh on the next text.
// ---------------------------------------------------------------------------
// One character is accepted every cycle unless a held verdict stalls it,
// with no stall between texts. The tag name stack lives in a synchronous
// name store and length store; each transfer prefetches the top entry at
// the column the next closing-tag character will compare, so the registered
// read of those memories keeps pace at one character per cycle. Open-tag
// names are written straight into the free row above the top, so a push
// costs only a length write. The verdict appears on the output in the cycle
// after the last character is transferred and is held until taken; the
// input stays ready while the output register is empty or being emptied.
// No clearing pass is needed after reset: no unwritten stack entry is used.
// ---------------------------------------------------------------------------
module html_tag_nesting_checker
    import htnc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    htnc_text_if.sink      text_stream,
    htnc_verdict_if.source result_stream
);

    logic     fire;
    ram_req_t req;
    ram_rsp_t rsp;
    result_t  res;

    logic       out_valid_reg;
    logic       verdict_reg;
    logic [2:0] kind_reg;

    // Accept while the output register is free or being emptied
    assign text_stream.ready = !out_valid_reg || result_stream.ready;
    assign fire              = text_stream.valid && text_stream.ready;

    htnc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .character (text_stream.character),
        .last_char (text_stream.last_char),
        .rsp       (rsp),
        .req       (req),
        .result    (res)
    );

    htnc_stack_ram u_stack_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Output register: load a verdict, drop it once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_stream.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            verdict_reg <= res.verdict;
            kind_reg    <= res.kind;
        end
    end

    assign result_stream.valid      = out_valid_reg;
    assign result_stream.verdict    = verdict_reg;
    assign result_stream.error_kind = kind_reg;

    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && text_stream.last_char) |=>
            (out_valid_reg && (verdict_reg == (kind_reg != ERR_NONE))))
        else $error("verdict missing after last character");

endmodule

// ===== design/htnc_stack_ram.sv =====
// ---------------------------------------------------------------------------
// htnc_stack_ram: tag name store and tag length store
// Synchronous memories, one write and one read per cycle each, read data
// registered. The length read forwards a write to the same row.
// ---------------------------------------------------------------------------
module htnc_stack_ram
    import htnc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ram_req_t req,
    output ram_rsp_t rsp
);

    logic [7:0]       tag_mem [TAG_WORDS];
    logic [LEN_W-1:0] len_mem [STACK_DEPTH];

    logic [7:0]       tag_rd_reg;
    logic [LEN_W-1:0] len_rd_reg;
    logic             len_fwd;

    assign len_fwd = req.len_wr && (req.len_wr_addr == req.len_rd_addr);

    // Name characters: write and prefetch
    always_ff @(posedge clk)
    begin
        if (req.tag_wr)
        begin
            tag_mem[req.tag_wr_addr] <= req.tag_wr_data;
        end
        if (req.rd)
        begin
            tag_rd_reg <= tag_mem[req.tag_rd_addr];
        end
    end

    // Name lengths: write and prefetch, forward a push onto the new top
    always_ff @(posedge clk)
    begin
        if (req.len_wr)
        begin
            len_mem[req.len_wr_addr] <= req.len_wr_data;
        end
        if (req.rd)
        begin
            len_rd_reg <= len_fwd ? req.len_wr_data : len_mem[req.len_rd_addr];
        end
    end

    assign rsp.tag = tag_rd_reg;
    assign rsp.len = len_rd_reg;

    // Name characters go to the row above the top, never to the row prefetched
    a_no_tag_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (req.tag_wr && req.rd) |-> (req.tag_wr_addr != req.tag_rd_addr))
        else $error("tag store write hits the prefetched entry");

endmodule

// ===== design/htnc_parser.sv =====
// ---------------------------------------------------------------------------
// htnc_parser: tag scanner and stack control
// Tracks the parse mode, writes open-tag names straight into the free
// stack row, compares closing-tag characters against the prefetched top
// entry and issues the prefetch for the next character.
// ---------------------------------------------------------------------------
module htnc_parser
    import htnc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  logic [7:0] character,
    input  logic     last_char,
    input  ram_rsp_t rsp,
    output ram_req_t req,
    output result_t  result
);

    mode_t            mode_reg, mode_next;
    logic [LEN_W-1:0] name_len_reg, name_len_next;
    logic [LEN_W-1:0] cont_len_reg, cont_len_next;
    logic             name_end_reg, name_end_next;
    logic             match_reg, match_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    err_t             err_reg, err_next;
    logic [2:0]       img_reg, img_next;

    logic [LEN_W-1:0] eff_nl;
    logic             eff_ne;
    logic             is_gt;
    logic             is_slash;
    logic             is_space;
    logic             sp_full;
    logic             sp_empty;
    logic             skip_push;
    logic [SP_W-1:0]  top_next;
    err_t             kind;

    assign is_gt    = (character == CH_GT);
    assign is_slash = (character == CH_SLASH);
    assign is_space = (character == CH_SPACE);
    assign sp_full  = (sp_reg >= SP_W'(STACK_DEPTH));
    assign sp_empty = (sp_reg == '0);

    // A fresh open tag starts with an empty name
    assign eff_nl    = (mode_reg == MODE_AFTER_LT) ? '0 : name_len_reg;
    assign eff_ne    = (mode_reg == MODE_AFTER_LT) ? 1'b0 : name_end_reg;
    assign skip_push = (eff_nl >= LEN_W'(3)) && (&img_reg);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OUTSIDE;
            name_len_reg <= '0;
            cont_len_reg <= '0;
            name_end_reg <= 1'b0;
            match_reg    <= 1'b1;
            sp_reg       <= '0;
            err_reg      <= ERR_NONE;
            img_reg      <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            name_len_reg <= name_len_next;
            cont_len_reg <= cont_len_next;
            name_end_reg <= name_end_next;
            match_reg    <= match_next;
            sp_reg       <= sp_next;
            err_reg      <= err_next;
            img_reg      <= img_next;
        end
    end

    // Next state, memory requests and verdict
    always_comb
    begin
        mode_next     = mode_reg;
        name_len_next = name_len_reg;
        cont_len_next = cont_len_reg;
        name_end_next = name_end_reg;
        match_next    = match_reg;
        sp_next       = sp_reg;
        err_next      = err_reg;
        img_next      = img_reg;
        req           = '0;

        if (fire && (err_reg == ERR_NONE))
        begin
            case (mode_reg)
                MODE_OUTSIDE:
                begin
                    if (character == CH_LT)
                    begin
                        mode_next = MODE_AFTER_LT;
                    end
                end
                MODE_AFTER_LT, MODE_OPEN:
                begin
                    if ((mode_reg == MODE_AFTER_LT) && is_slash)
                    begin
                        mode_next     = MODE_CLOSE;
                        cont_len_next = '0;
                        match_next    = 1'b1;
                    end
                    else
                    begin
                        mode_next     = MODE_OPEN;
                        name_len_next = eff_nl;
                        name_end_next = eff_ne;
                        if (is_gt)
                        begin
                            // Push the name unless it begins with img
                            mode_next = MODE_OUTSIDE;
                            if (!skip_push)
                            begin
                                if (sp_full)
                                begin
                                    err_next = ERR_OVERFLOW;
                                end
                                else
                                begin
                                    req.len_wr      = 1'b1;
                                    req.len_wr_addr = sp_reg[ROW_W-1:0];
                                    req.len_wr_data = eff_nl;
                                    sp_next         = sp_reg + SP_W'(1);
                                end
                            end
                        end
                        else if (eff_ne)
                        begin
                            // Attribute text: drop
                            name_end_next = 1'b1;
                        end
                        else if (is_space || is_slash)
                        begin
                            name_end_next = 1'b1;
                        end
                        else if (eff_nl >= LEN_W'(MAX_TAG_LEN))
                        begin
                            err_next = ERR_OVERFLOW;
                        end
                        else
                        begin
                            // Store the name character in the free row; a final
                            // character starts a new text, so skip its store
                            req.tag_wr      = !sp_full && !last_char;
                            req.tag_wr_addr = {sp_reg[ROW_W-1:0], eff_nl[COL_W-1:0]};
                            req.tag_wr_data = character;
                            name_len_next   = eff_nl + LEN_W'(1);
                            if (eff_nl == LEN_W'(0))
                            begin
                                img_next[0] = (character == CH_I);
                            end
                            if (eff_nl == LEN_W'(1))
                            begin
                                img_next[1] = (character == CH_M);
                            end
                            if (eff_nl == LEN_W'(2))
                            begin
                                img_next[2] = (character == CH_G);
                            end
                        end
                    end
                end
                default:
                begin
                    // Closing tag
                    if (is_gt)
                    begin
                        mode_next = MODE_OUTSIDE;
                        if (sp_empty)
                        begin
                            err_next = ERR_EMPTY;
                        end
                        else if (match_reg && (cont_len_reg == rsp.len))
                        begin
                            sp_next = sp_reg - SP_W'(1);
                        end
                        else
                        begin
                            err_next = ERR_MISMATCH;
                        end
                    end
                    else
                    begin
                        if ((cont_len_reg >= LEN_W'(MAX_TAG_LEN)) || sp_empty)
                        begin
                            match_next = 1'b0;
                        end
                        else if ((cont_len_reg >= rsp.len) || (rsp.tag != character))
                        begin
                            match_next = 1'b0;
                        end
                        if (cont_len_reg < LEN_W'(MAX_TAG_LEN))
                        begin
                            cont_len_next = cont_len_reg + LEN_W'(1);
                        end
                    end
                end
            endcase
        end

        // Verdict from the state this character leaves
        if (err_next != ERR_NONE)
        begin
            kind = err_next;
        end
        else if (mode_next != MODE_OUTSIDE)
        begin
            kind = ERR_UNTERM;
        end
        else if (sp_next != '0)
        begin
            kind = ERR_UNCLOSED;
        end
        else
        begin
            kind = ERR_NONE;
        end

        result.valid   = fire && last_char;
        result.verdict = (kind != ERR_NONE);
        result.kind    = kind;

        // Start a new text after the verdict
        if (fire && last_char)
        begin
            mode_next     = MODE_OUTSIDE;
            name_len_next = '0;
            cont_len_next = '0;
            name_end_next = 1'b0;
            match_next    = 1'b1;
            sp_next       = '0;
            err_next      = ERR_NONE;
            img_next      = '0;
        end

        // Prefetch the top entry at the column the next character compares
        top_next        = sp_next - SP_W'(1);
        req.rd          = fire;
        req.tag_rd_addr = {top_next[ROW_W-1:0], cont_len_next[COL_W-1:0]};
        req.len_rd_addr = top_next[ROW_W-1:0];
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ((err_reg != ERR_NONE) && !(fire && last_char)) |=> (err_reg == $past(err_reg)))
        else $error("first error was overwritten");

    a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_char) |=>
            ((sp_reg == '0) && (err_reg == ERR_NONE) && (mode_reg == MODE_OUTSIDE)))
        else $error("state not cleared after verdict");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the tag nesting checker
// Streams texts one character per transfer and checks every verdict against
// a bench-side model of the tag stack, or against the outcome that a typed
// table row expects. A table of short texts covering the corner cases runs
// first. Random texts follow, mostly well nested with random names and
// attributes, plus some deliberately broken ones and some noise. The sender
// and receiver idle at rates set for each phase.
module testbench;
    import htnc_pkg::*;

    // Two markers stand for the byte extremes inside table texts
    localparam logic [7:0] MARK_NUL = "@";
    localparam logic [7:0] MARK_FF  = "~";

    localparam int PHASES = 5;
    localparam int PHASE_CHARS = 320;
    localparam int SEND_IDLE [PHASES]  = '{0, 0, 83, 0, 35};
    localparam int RECV_STALL [PHASES] = '{0, 0, 0, 83, 35};

    typedef struct packed {
        logic       verdict;
        err_t       kind;
    } outcome_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        err_t       want;
    } text_item_t;

    typedef struct {
        string      text;
        bit         typed;
        err_t       want;
    } text_row_t;

    logic clk;
    logic rst_n;

    htnc_text_if    text_bus ();
    htnc_verdict_if verdict_bus ();

    html_tag_nesting_checker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_stream   (text_bus),
        .result_stream (verdict_bus)
    );

    text_item_t chars_to_send [$];
    text_item_t held_item;
    outcome_t   verdicts_due [$];
    int         fault_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    // Bench-side copy of the parser and tag stack
    mode_t            scan_mode;
    logic [7:0]       name_buf [MAX_TAG_LEN];
    logic [LEN_W-1:0] name_len;
    logic [LEN_W-1:0] content_len;
    logic             name_done;
    logic             still_match;
    logic [7:0]       tag_rows [STACK_DEPTH][MAX_TAG_LEN];
    logic [LEN_W-1:0] tag_lens [STACK_DEPTH];
    logic [SP_W-1:0]  depth_now;
    err_t             first_err;

    text_row_t directed_rows [25] = '{
        '{"x", 1'b1, ERR_NONE},
        '{"<a><b></b></a>", 1'b1, ERR_NONE},
        '{"<></>", 1'b1, ERR_NONE},
        '{"<a/></a>", 1'b1, ERR_NONE},
        '{"<img src=~>", 1'b1, ERR_NONE},
        '{"<img></img>", 1'b1, ERR_EMPTY},
        '{"<im>", 1'b1, ERR_UNCLOSED},
        '{"<a></b>", 1'b1, ERR_MISMATCH},
        '{"</a>", 1'b1, ERR_EMPTY},
        '{"<a>", 1'b1, ERR_UNCLOSED},
        '{"<a>>", 1'b1, ERR_UNCLOSED},
        '{"<a", 1'b1, ERR_UNTERM},
        '{"<", 1'b1, ERR_UNTERM},
        '{"<a></a >", 1'b1, ERR_MISMATCH},
        '{"<a x<y></a>", 1'b0, ERR_NONE},
        '{"<a<b></a<b>", 1'b0, ERR_NONE},
        '{"<abcdefghijklmnop></abcdefghijklmnop>", 1'b1, ERR_NONE},
        '{"<abcdefghijklmnopq>", 1'b1, ERR_OVERFLOW},
        '{"</abcdefghijklmnopq>", 1'b1, ERR_EMPTY},
        '{"<a></abcdefghijklmnopq>", 1'b1, ERR_MISMATCH},
        '{"</a><b", 1'b1, ERR_EMPTY},
        '{"<><><><><><><><><><><><><><><><></></></></></></></></></></></></></></></></>",
          1'b0, ERR_NONE},
        '{"<><><><><><><><><><><><><><><><><>", 1'b1, ERR_OVERFLOW},
        '{"<~@ a></~@>", 1'b0, ERR_NONE},
        '{"@~", 1'b0, ERR_NONE}
    };

    // Return the parser and stack to their state at the start of a text
    function automatic void clear_scan();
        scan_mode   = MODE_OUTSIDE;
        name_len    = '0;
        content_len = '0;
        name_done   = 1'b0;
        still_match = 1'b1;
        depth_now   = '0;
        first_err   = ERR_NONE;
    endfunction

    // Advance the model by one character; give a verdict on the last one
    function automatic void scan_character(input logic [7:0] c, input logic last,
                                           output logic got, output outcome_t res);
        logic [SP_W-1:0] top;
        logic            skip;
        err_t            kind;
        got = 1'b0;
        res = '0;
        top = depth_now - 1'b1;
        if (first_err == ERR_NONE)
        begin
            if (scan_mode == MODE_AFTER_LT && c == CH_SLASH)
            begin
                scan_mode   = MODE_CLOSE;
                content_len = '0;
                still_match = 1'b1;
            end
            else if (scan_mode == MODE_AFTER_LT || scan_mode == MODE_OPEN)
            begin
                if (scan_mode == MODE_AFTER_LT)
                begin
                    scan_mode = MODE_OPEN;
                    name_len  = '0;
                    name_done = 1'b0;
                end
                if (c == CH_GT)
                begin
                    // Push the name unless it starts with img
                    skip = name_len >= 3 && name_buf[0] == CH_I &&
                           name_buf[1] == CH_M && name_buf[2] == CH_G;
                    scan_mode = MODE_OUTSIDE;
                    if (!skip)
                    begin
                        if (depth_now >= STACK_DEPTH)
                        begin
                            first_err = ERR_OVERFLOW;
                        end
                        else
                        begin
                            tag_rows[depth_now] = name_buf;
                            tag_lens[depth_now] = name_len;
                            depth_now = depth_now + 1'b1;
                        end
                    end
                end
                else if (name_done)
                begin
                    // attribute text: drop
                end
                else if (c == CH_SPACE || c == CH_SLASH)
                begin
                    name_done = 1'b1;
                end
                else if (name_len >= MAX_TAG_LEN)
                begin
                    first_err = ERR_OVERFLOW;
                end
                else
                begin
                    name_buf[name_len] = c;
                    name_len = name_len + 1'b1;
                end
            end
            else if (scan_mode == MODE_CLOSE)
            begin
                if (c == CH_GT)
                begin
                    scan_mode = MODE_OUTSIDE;
                    if (depth_now == 0)
                        first_err = ERR_EMPTY;
                    else if (still_match && content_len == tag_lens[top])
                        depth_now = top;
                    else
                        first_err = ERR_MISMATCH;
                end
                else
                begin
                    if (content_len >= MAX_TAG_LEN || depth_now == 0)
                        still_match = 1'b0;
                    else if (content_len >= tag_lens[top] || tag_rows[top][content_len] != c)
                        still_match = 1'b0;
                    if (content_len < MAX_TAG_LEN)
                        content_len = content_len + 1'b1;
                end
            end
            else if (c == CH_LT)
            begin
                scan_mode = MODE_AFTER_LT;
            end
        end
        if (last)
        begin
            if (first_err != ERR_NONE)
                kind = first_err;
            else if (scan_mode != MODE_OUTSIDE)
                kind = ERR_UNTERM;
            else if (depth_now != 0)
                kind = ERR_UNCLOSED;
            else
                kind = ERR_NONE;
            res.verdict = (kind != ERR_NONE);
            res.kind    = kind;
            got         = 1'b1;
            clear_scan();
        end
    endfunction

    // Pick a tag name character, mostly from a small alphabet so names collide
    function automatic byte unsigned name_char();
        byte unsigned b;
        if ($urandom_range(99) < 75)
        begin
            case ($urandom_range(4))
                0:       b = "a";
                1:       b = "b";
                2:       b = CH_I;
                3:       b = CH_M;
                default: b = CH_G;
            endcase
        end
        else
        begin
            b = 8'($urandom_range(255));
            if (b == CH_SPACE || b == CH_SLASH || b == CH_GT)
                b = "z";
        end
        return b;
    endfunction

    // Append a closing tag for the given name, optionally spoilt
    task automatic append_close(ref byte unsigned text_q[$], input byte unsigned tag[$],
                                input bit spoil);
        byte unsigned body [$];
        body = tag;
        if (spoil)
        begin
            case ($urandom_range(3))
                0:
                begin
                    if (body.size() != 0)
                        body[$urandom_range(body.size() - 1)] = name_char();
                    else
                        body.push_back(name_char());
                end
                1:       body.push_back(CH_SPACE);
                2:       body.push_back(name_char());
                default:
                begin
                    if (body.size() != 0)
                        void'(body.pop_back());
                    else
                        body.push_back(CH_SLASH);
                end
            endcase
        end
        text_q.push_back(CH_LT);
        text_q.push_back(CH_SLASH);
        foreach (body[k])
            text_q.push_back(body[k]);
        text_q.push_back(CH_GT);
    endtask

    // Build one random text and queue its characters; give back its length
    task automatic compose_text(output int count);
        byte unsigned t [$];
        byte unsigned names [24][$];
        byte unsigned tag_q [$];
        byte unsigned b;
        int           depth;
        int           limit;
        int           open_pct;
        int           steps;
        int           r;
        int           n;
        text_item_t   item;
        if ($urandom_range(99) < 20)
        begin
            // Noise, rich in the characters that drive the parser
            repeat ($urandom_range(1, 30))
            begin
                case ($urandom_range(9))
                    0:       b = CH_LT;
                    1:       b = CH_GT;
                    2:       b = CH_SLASH;
                    3:       b = CH_SPACE;
                    4:       b = "a";
                    default: b = 8'($urandom_range(255));
                endcase
                t.push_back(b);
            end
        end
        else
        begin
            // Mostly well nested; a deep text now and then to reach a full stack
            if ($urandom_range(99) < 8)
            begin
                limit    = 18;
                open_pct = 75;
                steps    = 40;
            end
            else
            begin
                limit    = 5;
                open_pct = 40;
                steps    = $urandom_range(1, 12);
            end
            depth = 0;
            repeat (steps)
            begin
                r = $urandom_range(99);
                if (r < open_pct && depth < limit)
                begin
                    names[depth] = {};
                    n = ($urandom_range(99) < 6) ? $urandom_range(14, 18) : $urandom_range(0, 4);
                    repeat (n)
                        names[depth].push_back(name_char());
                    t.push_back(CH_LT);
                    tag_q = names[depth];
                    foreach (tag_q[k])
                        t.push_back(tag_q[k]);
                    if (n > 0 && $urandom_range(99) < 25)
                    begin
                        t.push_back($urandom_range(1) ? CH_SPACE : CH_SLASH);
                        repeat ($urandom_range(0, 5))
                        begin
                            b = 8'($urandom_range(255));
                            t.push_back(b == CH_GT ? CH_SPACE : b);
                        end
                    end
                    t.push_back(CH_GT);
                    depth++;
                end
                else if (r < open_pct + 8)
                begin
                    t.push_back(CH_LT);
                    t.push_back(CH_I);
                    t.push_back(CH_M);
                    t.push_back(CH_G);
                    repeat ($urandom_range(0, 2))
                        t.push_back(name_char());
                    if ($urandom_range(1))
                    begin
                        t.push_back(CH_SPACE);
                        t.push_back("x");
                    end
                    t.push_back(CH_GT);
                end
                else if (r < open_pct + 40 && (depth > 0 || $urandom_range(99) < 5))
                begin
                    append_close(t, names[depth > 0 ? depth - 1 : 0], $urandom_range(99) < 6);
                    if (depth > 0)
                        depth--;
                end
                else
                begin
                    repeat ($urandom_range(0, 4))
                    begin
                        b = 8'($urandom_range(255));
                        t.push_back(b == CH_LT ? "." : b);
                    end
                end
            end
            // Close what is still open, leaving some texts unclosed
            while (depth > 0 && $urandom_range(99) >= 6)
            begin
                append_close(t, names[depth - 1], $urandom_range(99) < 4);
                depth--;
            end
            if (t.size() > 1 && $urandom_range(99) < 6)
                void'(t.pop_back());
        end
        if (t.size() == 0)
            t.push_back(8'($urandom_range(255)));
        foreach (t[k])
        begin
            item.ch    = t[k];
            item.last  = (k == t.size() - 1);
            item.typed = 1'b0;
            item.want  = ERR_NONE;
            chars_to_send.push_back(item);
        end
        count = t.size();
    endtask

    // Clock
    always #1 clk = ~clk;

    // Feed characters, idling at the sender rate of the phase
    always @(posedge clk)
    begin : feed
        text_item_t next_item;
        if (!rst_n)
        begin
            text_bus.valid     <= 1'b0;
            text_bus.character <= '0;
            text_bus.last_char <= 1'b0;
        end
        else if (!text_bus.valid || text_bus.ready)
        begin
            if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = chars_to_send.pop_front();
                held_item <= next_item;
                text_bus.valid <= 1'b1;
                text_bus.character <= next_item.ch;
                text_bus.last_char <= next_item.last;
            end
            else
            begin
                text_bus.valid <= 1'b0;
            end
        end
    end

    // Stall the verdict stream at the receiver rate of the phase
    always @(posedge clk)
        verdict_bus.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    // Predict on each character transfer, check each verdict transfer
    always @(posedge clk)
    begin : watch
        logic     got;
        outcome_t predicted;
        outcome_t want;
        if (!rst_n)
        begin
            clear_scan();
        end
        else
        begin
            if (text_bus.valid && text_bus.ready)
            begin
                scan_character(text_bus.character, text_bus.last_char, got, predicted);
                if (got)
                begin
                    if (held_item.typed)
                    begin
                        predicted.verdict = (held_item.want != ERR_NONE);
                        predicted.kind    = held_item.want;
                    end
                    verdicts_due.push_back(predicted);
                end
            end
            if (verdict_bus.valid && verdict_bus.ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected verdict: got verdict %0d kind %0d",
                                 verdict_bus.verdict, verdict_bus.error_kind);
                    fault_count++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (verdict_bus.verdict !== want.verdict ||
                        verdict_bus.error_kind !== want.kind)
                    begin
                        if (fault_count < 10)
                            $display("verdict mismatch: expected %0d kind %0d, got %0d kind %0d",
                                     want.verdict, want.kind,
                                     verdict_bus.verdict, verdict_bus.error_kind);
                        fault_count++;
                    end
                end
            end
        end
    end

    // Run the table, then the random phases
    initial
    begin : sequencer
        int         p;
        int         n;
        int         phase_chars;
        text_item_t item;
        clk   = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < PHASES; p++)
        begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            if (p == 0)
            begin
                foreach (directed_rows[r])
                begin
                    for (int k = 0; k < directed_rows[r].text.len(); k++)
                    begin
                        item.ch = directed_rows[r].text[k];
                        if (item.ch == MARK_NUL)
                            item.ch = 8'h00;
                        else if (item.ch == MARK_FF)
                            item.ch = 8'hFF;
                        item.last  = (k == directed_rows[r].text.len() - 1);
                        item.typed = directed_rows[r].typed;
                        item.want  = directed_rows[r].want;
                        chars_to_send.push_back(item);
                    end
                end
            end
            else
            begin
                phase_chars = 0;
                while (phase_chars < PHASE_CHARS)
                begin
                    compose_text(n);
                    phase_chars += n;
                end
            end
            // Hold until every character is sent and every verdict is back
            @(negedge clk);
            while (chars_to_send.size() != 0 || text_bus.valid || verdicts_due.size() != 0)
                @(negedge clk);
        end

        // Let any stray verdict show up
        repeat (20) @(posedge clk);
        if (fault_count == 0 && verdicts_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/htnc_pkg.sv
design/htnc_if.sv
design/htnc_stack_ram.sv
design/htnc_parser.sv
design/html_tag_nesting_checker.sv
bench/testbench.sv
